>>> rtl/ihss_pkg.sv
// ----------------------------------------------------------------------------
// ihss_pkg
// Shared types and constants for the image header size sniffer.
// ----------------------------------------------------------------------------
package ihss_pkg;

  localparam int INDEX_WIDTH_DEF = 32;
  localparam int DATA_W          = 8;
  localparam int DIM_W           = 32;
  localparam int SEG_W           = 16;

  typedef enum logic [2:0] {
    KIND_NONE = 3'd0,
    KIND_PNG  = 3'd1,
    KIND_GIF  = 3'd2,
    KIND_BMP  = 3'd3,
    KIND_JPEG = 3'd4,
    KIND_DEAD = 3'd5
  } format_kind_t;

  typedef enum logic [2:0] {
    PH_SEEK  = 3'd0,
    PH_MARK  = 3'd1,
    PH_LENHI = 3'd2,
    PH_LENLO = 3'd3,
    PH_SKIP  = 3'd4,
    PH_FRAME = 3'd5
  } jpeg_phase_t;

  // Signature and marker bytes
  localparam logic [7:0] SIG_PNG0  = 8'h89;
  localparam logic [7:0] SIG_P     = 8'h50;
  localparam logic [7:0] SIG_N     = 8'h4e;
  localparam logic [7:0] SIG_G     = 8'h47;
  localparam logic [7:0] SIG_I     = 8'h49;
  localparam logic [7:0] SIG_F     = 8'h46;
  localparam logic [7:0] SIG_B     = 8'h42;
  localparam logic [7:0] SIG_M     = 8'h4d;
  localparam logic [7:0] MK_PREFIX = 8'hff;
  localparam logic [7:0] MK_SOI    = 8'hd8;
  localparam logic [7:0] MK_TEM    = 8'h01;
  localparam logic [7:0] MK_RST0   = 8'hd0;
  localparam logic [7:0] MK_RST7   = 8'hd7;
  localparam logic [7:0] MK_EOI    = 8'hd9;
  localparam logic [7:0] MK_SOS    = 8'hda;
  localparam logic [7:0] MK_SOF_LO = 8'hc0;
  localparam logic [7:0] MK_SOF_HI = 8'hcf;
  localparam logic [7:0] MK_DHT    = 8'hc4;
  localparam logic [7:0] MK_JPG    = 8'hc8;
  localparam logic [7:0] MK_DAC    = 8'hcc;

  typedef struct packed {
    format_kind_t      kind;
    jpeg_phase_t       phase;
    logic [7:0]        marker_code;
    logic [SEG_W-1:0]  segment_left;
    logic [DIM_W-1:0]  held_width;
    logic [DIM_W-1:0]  field_shift;
    logic              result_given;
  } parse_state_t;

  localparam parse_state_t PARSE_RESET = '{
    kind:         KIND_NONE,
    phase:        PH_SEEK,
    marker_code:  8'h00,
    segment_left: '0,
    held_width:   '0,
    field_shift:  '0,
    result_given: 1'b0
  };

endpackage

>>> rtl/ihss_if.sv
// ----------------------------------------------------------------------------
// ihss channel interfaces
// Valid/ready channels for the byte stream in and the size result out.
// ----------------------------------------------------------------------------
interface ihss_in_if;
  logic                       valid;
  logic                       ready;
  logic [ihss_pkg::DATA_W-1:0] data_byte;
  logic                       last_byte;

  modport source (output valid, data_byte, last_byte, input ready);
  modport sink   (input valid, data_byte, last_byte, output ready);
endinterface

interface ihss_out_if;
  logic                       valid;
  logic                       ready;
  logic                       found;
  logic [ihss_pkg::DIM_W-1:0] image_width;
  logic [ihss_pkg::DIM_W-1:0] image_height;

  modport source (output valid, found, image_width, image_height, input ready);
  modport sink   (input valid, found, image_width, image_height, output ready);
endinterface

>>> rtl/ihss_step.sv
// ----------------------------------------------------------------------------
// ihss_step
// One-byte parse step: next parse state, byte index and result.
// ----------------------------------------------------------------------------
module ihss_step #(
  parameter int INDEX_WIDTH = ihss_pkg::INDEX_WIDTH_DEF
) (
  input  ihss_pkg::parse_state_t       st,
  input  logic [INDEX_WIDTH-1:0]       idx,
  input  logic [ihss_pkg::DATA_W-1:0]  b,
  input  logic                         last,
  output ihss_pkg::parse_state_t       st_nxt,
  output logic [INDEX_WIDTH-1:0]       idx_nxt,
  output logic                         emit,
  output logic                         found,
  output logic [ihss_pkg::DIM_W-1:0]   width,
  output logic [ihss_pkg::DIM_W-1:0]   height
);

  // OR a byte into one of four little-endian byte lanes
  function automatic logic [ihss_pkg::DIM_W-1:0] or_lane(
    input logic [ihss_pkg::DIM_W-1:0]  word,
    input logic [ihss_pkg::DATA_W-1:0] v,
    input logic [1:0]                  lane
  );
    logic [ihss_pkg::DIM_W-1:0] ext;
    ext = {24'h0, v};
    return word | (ext << {lane, 3'b000});
  endfunction

  logic                       hit;
  logic                       is_frame;
  logic [ihss_pkg::SEG_W-1:0] seg_len;
  logic [ihss_pkg::DIM_W-1:0] bmp_h;

  assign is_frame = (st.marker_code >= ihss_pkg::MK_SOF_LO) &&
                    (st.marker_code <= ihss_pkg::MK_SOF_HI) &&
                    (st.marker_code != ihss_pkg::MK_DHT) &&
                    (st.marker_code != ihss_pkg::MK_JPG) &&
                    (st.marker_code != ihss_pkg::MK_DAC);
  assign seg_len = st.segment_left | {8'h00, b};
  assign bmp_h   = or_lane(st.field_shift, b, 2'(idx[1:0] - 2'd2));

  always_comb begin
    st_nxt = st;
    hit    = 1'b0;
    if (!st.result_given && st.kind != ihss_pkg::KIND_DEAD) begin
      if (idx == '0) begin
        if (b == ihss_pkg::SIG_PNG0)       st_nxt.kind = ihss_pkg::KIND_PNG;
        else if (b == ihss_pkg::SIG_G)     st_nxt.kind = ihss_pkg::KIND_GIF;
        else if (b == ihss_pkg::SIG_B)     st_nxt.kind = ihss_pkg::KIND_BMP;
        else if (b == ihss_pkg::MK_PREFIX) st_nxt.kind = ihss_pkg::KIND_JPEG;
        else                               st_nxt.kind = ihss_pkg::KIND_DEAD;
      end else begin
        unique case (st.kind)
          ihss_pkg::KIND_PNG: begin
            if ((idx == INDEX_WIDTH'(1) && b != ihss_pkg::SIG_P) ||
                (idx == INDEX_WIDTH'(2) && b != ihss_pkg::SIG_N) ||
                (idx == INDEX_WIDTH'(3) && b != ihss_pkg::SIG_G)) begin
              st_nxt.kind = ihss_pkg::KIND_DEAD;
            end else if (idx >= INDEX_WIDTH'(16) && idx <= INDEX_WIDTH'(19)) begin
              st_nxt.held_width = {st.held_width[23:0], b};
            end else if (idx >= INDEX_WIDTH'(20) && idx <= INDEX_WIDTH'(23)) begin
              st_nxt.field_shift = {st.field_shift[23:0], b};
              hit = (idx == INDEX_WIDTH'(23));
            end
          end
          ihss_pkg::KIND_GIF: begin
            if ((idx == INDEX_WIDTH'(1) && b != ihss_pkg::SIG_I) ||
                (idx == INDEX_WIDTH'(2) && b != ihss_pkg::SIG_F)) begin
              st_nxt.kind = ihss_pkg::KIND_DEAD;
            end else if (idx == INDEX_WIDTH'(6) || idx == INDEX_WIDTH'(7)) begin
              st_nxt.held_width = or_lane(st.held_width, b, 2'(idx[1:0] - 2'd2));
            end else if (idx == INDEX_WIDTH'(8) || idx == INDEX_WIDTH'(9)) begin
              st_nxt.field_shift = or_lane(st.field_shift, b, idx[1:0]);
              hit = (idx == INDEX_WIDTH'(9));
            end
          end
          ihss_pkg::KIND_BMP: begin
            if (idx == INDEX_WIDTH'(1) && b != ihss_pkg::SIG_M) begin
              st_nxt.kind = ihss_pkg::KIND_DEAD;
            end else if (idx >= INDEX_WIDTH'(18) && idx <= INDEX_WIDTH'(21)) begin
              st_nxt.held_width = or_lane(st.held_width, b, 2'(idx[1:0] - 2'd2));
            end else if (idx >= INDEX_WIDTH'(22) && idx <= INDEX_WIDTH'(25)) begin
              st_nxt.field_shift = bmp_h;
              if (idx == INDEX_WIDTH'(25)) begin
                // top-down bitmap: keep the magnitude
                if (bmp_h[31]) st_nxt.field_shift = 32'(~bmp_h + 32'd1);
                hit = 1'b1;
              end
            end
          end
          ihss_pkg::KIND_JPEG: begin
            if (idx == INDEX_WIDTH'(1)) begin
              if (b == ihss_pkg::MK_SOI) st_nxt.phase = ihss_pkg::PH_SEEK;
              else                       st_nxt.kind  = ihss_pkg::KIND_DEAD;
            end else begin
              unique case (st.phase)
                ihss_pkg::PH_SEEK: begin
                  if (b == ihss_pkg::MK_PREFIX) st_nxt.phase = ihss_pkg::PH_MARK;
                end
                ihss_pkg::PH_MARK: begin
                  if (b == ihss_pkg::MK_SOI || b == ihss_pkg::MK_TEM ||
                      (b >= ihss_pkg::MK_RST0 && b <= ihss_pkg::MK_RST7)) begin
                    st_nxt.phase = ihss_pkg::PH_SEEK;
                  end else if (b == ihss_pkg::MK_EOI || b == ihss_pkg::MK_SOS) begin
                    st_nxt.kind = ihss_pkg::KIND_DEAD;
                  end else begin
                    st_nxt.marker_code = b;
                    st_nxt.phase       = ihss_pkg::PH_LENHI;
                  end
                end
                ihss_pkg::PH_LENHI: begin
                  st_nxt.segment_left = {b, 8'h00};
                  st_nxt.phase        = ihss_pkg::PH_LENLO;
                end
                ihss_pkg::PH_LENLO: begin
                  if (seg_len < 16'd2) begin
                    st_nxt.kind = ihss_pkg::KIND_DEAD;
                  end else if (is_frame) begin
                    st_nxt.segment_left = '0;
                    st_nxt.field_shift  = '0;
                    st_nxt.held_width   = '0;
                    st_nxt.phase        = ihss_pkg::PH_FRAME;
                  end else begin
                    st_nxt.segment_left = seg_len - 16'd2;
                    st_nxt.phase = (seg_len != 16'd2) ? ihss_pkg::PH_SKIP
                                                      : ihss_pkg::PH_SEEK;
                  end
                end
                ihss_pkg::PH_SKIP: begin
                  st_nxt.segment_left = st.segment_left - 16'd1;
                  if (st.segment_left == 16'd1) st_nxt.phase = ihss_pkg::PH_SEEK;
                end
                ihss_pkg::PH_FRAME: begin
                  // counter 0: precision, 1-2 height, 3-4 width, 5 report
                  if (st.segment_left == 16'd5) begin
                    hit = 1'b1;
                  end else begin
                    if (st.segment_left == 16'd1 || st.segment_left == 16'd2)
                      st_nxt.field_shift = {16'h0, st.field_shift[7:0], b};
                    else if (st.segment_left == 16'd3 || st.segment_left == 16'd4)
                      st_nxt.held_width = {16'h0, st.held_width[7:0], b};
                    st_nxt.segment_left = st.segment_left + 16'd1;
                  end
                end
                default: st_nxt.kind = ihss_pkg::KIND_DEAD;
              endcase
            end
          end
          default: st_nxt.kind = ihss_pkg::KIND_DEAD;
        endcase
      end
    end

    if (hit) st_nxt.result_given = 1'b1;
    idx_nxt = (idx == '1) ? idx : idx + INDEX_WIDTH'(1);

    emit   = hit || (last && !st.result_given);
    found  = hit;
    width  = hit ? st_nxt.held_width  : '0;
    height = hit ? st_nxt.field_shift : '0;

    if (last) begin
      st_nxt  = ihss_pkg::PARSE_RESET;
      idx_nxt = '0;
    end
  end

endmodule

>>> rtl/image_header_size_sniffer_core.sv
// ----------------------------------------------------------------------------
// image_header_size_sniffer_core
// Streams the bytes of one image file, flagged on the last byte, and reports
// its width and height. PNG, GIF and BMP sizes come from fixed header
// offsets (BMP height as magnitude); JPEG is walked marker by marker to the
// first start-of-frame segment. Each image gives exactly one result: found=1
// as soon as the size is known, or found=0 with zero size at the last byte
// when no size was found: unknown format, truncated or malformed data. Bytes
// after a found result are absorbed up to the last byte. One byte is taken
// per clock while the result register can take a result; a byte passes the
// input register, the combinational parse logic and the result register.
// The result register loads when the byte moves on from the input register.
// The result register frees the input side for one byte: while a result
// waits, one more transfer is taken into the input register, and the input
// then stalls until the receiver takes the waiting result.
// ----------------------------------------------------------------------------
module image_header_size_sniffer_core #(
  parameter int INDEX_WIDTH = ihss_pkg::INDEX_WIDTH_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  ihss_in_if.sink    in_ch,
  ihss_out_if.source out_ch
);

  // Input register stage
  logic                         s1_valid_r;
  logic [ihss_pkg::DATA_W-1:0]  s1_byte_r;
  logic                         s1_last_r;

  // Parse state, byte position within the current image
  ihss_pkg::parse_state_t       st_r, st_nxt;
  logic [INDEX_WIDTH-1:0]       idx_r, idx_nxt;

  // Result register
  logic                         out_valid_r;
  logic                         found_r;
  logic [ihss_pkg::DIM_W-1:0]   width_r;
  logic [ihss_pkg::DIM_W-1:0]   height_r;

  logic                         emit;
  logic                         found;
  logic [ihss_pkg::DIM_W-1:0]   width;
  logic [ihss_pkg::DIM_W-1:0]   height;
  logic                         out_free;
  logic                         s1_fire;

  // The stage-1 byte moves on whenever the result slot can take a result.
  assign out_free     = !out_valid_r || out_ch.ready;
  assign s1_fire      = s1_valid_r && out_free;
  assign in_ch.ready  = !s1_valid_r || s1_fire;

  ihss_step #(
    .INDEX_WIDTH (INDEX_WIDTH)
  ) u_step (
    .st      (st_r),
    .idx     (idx_r),
    .b       (s1_byte_r),
    .last    (s1_last_r),
    .st_nxt  (st_nxt),
    .idx_nxt (idx_nxt),
    .emit    (emit),
    .found   (found),
    .width   (width),
    .height  (height)
  );

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      st_r        <= ihss_pkg::PARSE_RESET;
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_ch.ready) s1_valid_r <= in_ch.valid;
      if (s1_fire) begin
        st_r  <= st_nxt;
        idx_r <= idx_nxt;
      end
      if (s1_fire && emit) out_valid_r <= 1'b1;
      else if (out_ch.ready) out_valid_r <= 1'b0;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (in_ch.ready && in_ch.valid) begin
      s1_byte_r <= in_ch.data_byte;
      s1_last_r <= in_ch.last_byte;
    end
    if (s1_fire && emit) begin
      found_r  <= found;
      width_r  <= width;
      height_r <= height;
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.found        = found_r;
  assign out_ch.image_width  = width_r;
  assign out_ch.image_height = height_r;

  // The last byte always returns the parser to its start state.
  a_last_resets: assert property (@(posedge clk) disable iff (!rst_n)
    s1_fire && s1_last_r |=> idx_r == '0 && st_r.kind == ihss_pkg::KIND_NONE)
    else $error("parser not cleared after last byte");

  // A reported size means a recognized, live format.
  a_given_kind: assert property (@(posedge clk) disable iff (!rst_n)
    st_r.result_given |-> st_r.kind != ihss_pkg::KIND_NONE &&
                          st_r.kind != ihss_pkg::KIND_DEAD)
    else $error("result flagged without a recognized format");

  // A new result never overwrites one still waiting.
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    s1_fire && emit |-> !out_valid_r || out_ch.ready)
    else $error("result register overwritten");

  // A not-found result carries zero size.
  a_zero_miss: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !found_r |-> width_r == '0 && height_r == '0)
    else $error("non-zero size on a not-found result");

  // No second result once the size was given, until the last byte.
  a_single: assert property (@(posedge clk) disable iff (!rst_n)
    s1_fire && st_r.result_given |-> !emit)
    else $error("second result for one image");

endmodule

>>> tb/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for image_header_size_sniffer_core. Byte streams of
// PNG, GIF, BMP and JPEG images are driven into the core. Some streams are
// well formed, some are truncated, some have bad signatures and some are
// noise. A cycle-free model predicts one size report per image. The bench
// compares each output transfer with that prediction under several
// sender/receiver idling mixes and one long output hold-off.
// ----------------------------------------------------------------------------
module tb_top;
  import ihss_pkg::*;

  localparam int PHASE_BYTES   = 430;   // stimulus per idling phase
  localparam int PRESSURE_HOLD = 400;   // cycles the receiver holds ready low
  localparam int QUIET_LIMIT   = 5000;  // cycles without any transfer
  localparam int DRAIN_CYCLES  = 20;    // margin after the last report

  typedef struct packed {
    logic [DATA_W-1:0] data;
    logic              last;
  } byte_xfer_t;

  typedef struct packed {
    logic             found;
    logic [DIM_W-1:0] width;
    logic [DIM_W-1:0] height;
  } size_report_t;

  logic clk;
  logic rst_n;

  ihss_in_if  in_ch ();
  ihss_out_if out_ch ();

  image_header_size_sniffer_core dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  initial clk = 1'b0;
  always #10 clk = ~clk;

  // Stimulus bytes waiting for the driver, and reports still owed by the core.
  byte_xfer_t   byte_feed[$];
  size_report_t size_reports_due[$];
  logic [7:0]   img[$];

  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  bit pressure_on    = 1'b0;
  bit pressure_done  = 1'b0;
  int hold_cnt       = 0;

  int n_bytes       = 0;
  int n_images      = 0;
  int n_found       = 0;
  int n_missing     = 0;
  int n_in_stalls   = 0;
  int fails         = 0;
  int quiet_cycles  = 0;

  // --------------------------------------------------------------------------
  // Size sniffing model: its own copy of the parse state.
  // --------------------------------------------------------------------------
  logic [31:0]      idx;
  format_kind_t     kind;
  logic [DIM_W-1:0] hgt_acc;
  logic [DIM_W-1:0] wid_acc;
  jpeg_phase_t      jph;
  logic [7:0]       mcode;
  logic [SEG_W-1:0] seg_cnt;
  logic             reported;

  function automatic void clear_sniffer();
    idx      = '0;
    kind     = KIND_NONE;
    hgt_acc  = '0;
    wid_acc  = '0;
    jph      = PH_SEEK;
    mcode    = '0;
    seg_cnt  = '0;
    reported = 1'b0;
  endfunction

  // JPEG marker walk; returns 1 on the byte after the frame width.
  function automatic bit walk_jpeg(input logic [7:0] b);
    logic [SEG_W-1:0] seg_len;
    bit               is_frame;
    walk_jpeg = 1'b0;
    case (jph)
      PH_SEEK: begin
        if (b == MK_PREFIX) jph = PH_MARK;
      end
      PH_MARK: begin
        if (b == MK_SOI || b == MK_TEM || (b >= MK_RST0 && b <= MK_RST7)) begin
          jph = PH_SEEK;
        end else if (b == MK_EOI || b == MK_SOS) begin
          kind = KIND_DEAD;
        end else begin
          mcode = b;
          jph   = PH_LENHI;
        end
      end
      PH_LENHI: begin
        seg_cnt = {b, 8'h00};
        jph     = PH_LENLO;
      end
      PH_LENLO: begin
        seg_len  = seg_cnt | {8'h00, b};
        is_frame = mcode >= MK_SOF_LO && mcode <= MK_SOF_HI &&
                   mcode != MK_DHT && mcode != MK_JPG && mcode != MK_DAC;
        if (seg_len < 2) begin
          kind = KIND_DEAD;
        end else if (is_frame) begin
          seg_cnt = '0;
          hgt_acc = '0;
          wid_acc = '0;
          jph     = PH_FRAME;
        end else begin
          seg_cnt = seg_len - 16'd2;
          if (seg_cnt != 0) jph = PH_SKIP;
          else jph = PH_SEEK;
        end
      end
      PH_SKIP: begin
        seg_cnt = seg_cnt - 16'd1;
        if (seg_cnt == 0) jph = PH_SEEK;
      end
      PH_FRAME: begin
        // precision, height hi/lo, width hi/lo, then one more byte
        if (seg_cnt == 1 || seg_cnt == 2) hgt_acc = {16'h0, hgt_acc[7:0], b};
        else if (seg_cnt == 3 || seg_cnt == 4) wid_acc = {16'h0, wid_acc[7:0], b};
        if (seg_cnt == 5) walk_jpeg = 1'b1;
        else seg_cnt = seg_cnt + 16'd1;
      end
      default: kind = KIND_DEAD;
    endcase
  endfunction

  function automatic bit parse_header(input logic [7:0] b);
    parse_header = 1'b0;
    if (idx == 0) begin
      if (b == SIG_PNG0) kind = KIND_PNG;
      else if (b == SIG_G) kind = KIND_GIF;
      else if (b == SIG_B) kind = KIND_BMP;
      else if (b == MK_PREFIX) kind = KIND_JPEG;
      else kind = KIND_DEAD;
    end else begin
      case (kind)
        KIND_PNG: begin
          if ((idx == 1 && b != SIG_P) || (idx == 2 && b != SIG_N) ||
              (idx == 3 && b != SIG_G)) begin
            kind = KIND_DEAD;
          end else if (idx >= 16 && idx <= 19) begin
            wid_acc = {wid_acc[23:0], b};
          end else if (idx >= 20 && idx <= 23) begin
            hgt_acc      = {hgt_acc[23:0], b};
            parse_header = (idx == 23);
          end
        end
        KIND_GIF: begin
          if ((idx == 1 && b != SIG_I) || (idx == 2 && b != SIG_F)) begin
            kind = KIND_DEAD;
          end else if (idx == 6 || idx == 7) begin
            wid_acc = wid_acc | ({24'h0, b} << (8 * (idx - 6)));
          end else if (idx == 8 || idx == 9) begin
            hgt_acc      = hgt_acc | ({24'h0, b} << (8 * (idx - 8)));
            parse_header = (idx == 9);
          end
        end
        KIND_BMP: begin
          if (idx == 1 && b != SIG_M) begin
            kind = KIND_DEAD;
          end else if (idx >= 18 && idx <= 21) begin
            wid_acc = wid_acc | ({24'h0, b} << (8 * (idx - 18)));
          end else if (idx >= 22 && idx <= 25) begin
            hgt_acc = hgt_acc | ({24'h0, b} << (8 * (idx - 22)));
            if (idx == 25) begin
              // top-down bitmap: keep the magnitude
              if (hgt_acc[31]) hgt_acc = -hgt_acc;
              parse_header = 1'b1;
            end
          end
        end
        KIND_JPEG: begin
          if (idx == 1) begin
            if (b == MK_SOI) jph = PH_SEEK;
            else kind = KIND_DEAD;
          end else begin
            parse_header = walk_jpeg(b);
          end
        end
        default: kind = KIND_DEAD;
      endcase
    end
  endfunction

  // One accepted byte: advance the model, queue the report it causes.
  function automatic void sniff_byte(input logic [7:0] b, input logic last);
    bit hit;
    hit = 1'b0;
    if (!reported && kind != KIND_DEAD) hit = parse_header(b);
    if (idx != {32{1'b1}}) idx = idx + 1;
    if (hit) begin
      reported = 1'b1;
      size_reports_due.push_back('{1'b1, wid_acc, hgt_acc});
    end else if (last && !reported) begin
      size_reports_due.push_back('{1'b0, '0, '0});
    end
    if (last) clear_sniffer();
  endfunction

  // --------------------------------------------------------------------------
  // Image builders
  // --------------------------------------------------------------------------
  function automatic void put(input logic [7:0] b);
    img.push_back(b);
  endfunction

  function automatic logic [7:0] dim_byte();
    case ($urandom_range(0, 5))
      0:       return 8'h00;
      1:       return 8'hff;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic logic [7:0] sof_marker();
    logic [7:0] m;
    do m = MK_SOF_LO + 8'($urandom_range(0, 15));
    while (m == MK_DHT || m == MK_JPG || m == MK_DAC);
    return m;
  endfunction

  // Move the buffered image to the feed, last flag on its final byte.
  function automatic void ship_img();
    foreach (img[k]) byte_feed.push_back('{img[k], k == img.size() - 1});
    n_bytes += img.size();
    img.delete();
  endfunction

  // Optional damage: bad signature, trailing junk, truncation.
  function automatic void finish_img(input int sig_len);
    int k;
    int keep;
    if ($urandom_range(0, 9) == 0) begin
      k      = $urandom_range(1, sig_len - 1);
      img[k] = img[k] ^ 8'($urandom_range(1, 255));
    end
    if ($urandom_range(0, 2) != 0)
      repeat ($urandom_range(1, 6)) put(8'($urandom_range(0, 255)));
    if ($urandom_range(0, 7) == 0) begin
      keep = $urandom_range(1, img.size());
      while (img.size() > keep) void'(img.pop_back());
    end
    ship_img();
  endfunction

  function automatic void gen_png();
    put(SIG_PNG0); put(SIG_P); put(SIG_N); put(SIG_G);
    repeat (12) put(8'($urandom_range(0, 255)));
    repeat (8) put(dim_byte());
    finish_img(4);
  endfunction

  function automatic void gen_gif();
    put(SIG_G); put(SIG_I); put(SIG_F);
    repeat (3) put(8'($urandom_range(0, 255)));
    repeat (4) put(dim_byte());
    finish_img(3);
  endfunction

  function automatic void gen_bmp();
    logic [31:0] h;
    put(SIG_B); put(SIG_M);
    repeat (16) put(8'($urandom_range(0, 255)));
    repeat (4) put(dim_byte());
    case ($urandom_range(0, 3))
      0:       h = 32'h8000_0000;               // negation leaves it as is
      1:       h = {1'b1, 31'($urandom)};       // top-down, negative
      default: h = {dim_byte(), dim_byte(), dim_byte(), dim_byte()};
    endcase
    for (int k = 0; k < 4; k++) put(h[8*k +: 8]);
    finish_img(2);
  endfunction

  function automatic void gen_jpeg();
    int         len;
    logic [7:0] mk;
    put(MK_PREFIX); put(MK_SOI);
    repeat ($urandom_range(0, 4)) begin
      case ($urandom_range(0, 9))
        0: repeat ($urandom_range(1, 3)) put(8'($urandom_range(0, 254)));
        1: begin
          put(MK_PREFIX);
          case ($urandom_range(0, 2))
            0:       put(MK_SOI);
            1:       put(MK_TEM);
            default: put(MK_RST0 + 8'($urandom_range(0, 7)));
          endcase
        end
        default: begin
          case ($urandom_range(0, 7))
            0:       mk = MK_DHT;
            1:       mk = MK_JPG;
            2:       mk = MK_DAC;
            3:       mk = MK_PREFIX;
            default: mk = 8'($urandom_range(0, 255));
          endcase
          if ($urandom_range(0, 15) == 0) len = $urandom_range(2, 300);
          else len = $urandom_range(2, 8);
          put(MK_PREFIX); put(mk); put(8'(len >> 8)); put(8'(len));
          repeat (len - 2) put(8'($urandom_range(0, 255)));
        end
      endcase
    end
    case ($urandom_range(0, 9))
      0: begin
        put(MK_PREFIX);
        put($urandom_range(0, 1) ? MK_EOI : MK_SOS);
      end
      1: begin
        // segment length below two
        put(MK_PREFIX); put($urandom_range(0, 1) ? sof_marker() : MK_DHT);
        put(8'h00); put(8'($urandom_range(0, 1)));
      end
      default: begin
        put(MK_PREFIX); put(sof_marker());
        put(8'($urandom_range(0, 255))); put(8'($urandom_range(2, 255)));
        put(8'($urandom_range(0, 255)));
        repeat (4) put(dim_byte());
        put(8'($urandom_range(0, 255)));
      end
    endcase
    finish_img(2);
  endfunction

  function automatic void gen_noise(input int max_len);
    repeat ($urandom_range(1, max_len)) put(8'($urandom_range(0, 255)));
    ship_img();
  endfunction

  function automatic void gen_images(input int count);
    int stop_at;
    stop_at = n_bytes + count;
    while (n_bytes < stop_at) begin
      case ($urandom_range(0, 19))
        0, 1, 2:          gen_png();
        3, 4, 5:          gen_gif();
        6, 7, 8:          gen_bmp();
        9, 10, 11, 12,
        13, 14, 15:       gen_jpeg();
        default:          gen_noise(6);
      endcase
    end
  endfunction

  // --------------------------------------------------------------------------
  // Driver: presents the next byte, unless it idles at random, when the channel is free.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin : byte_driver
    byte_xfer_t nxt;
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else if (!in_ch.valid || in_ch.ready) begin
      if (byte_feed.size() != 0 && $urandom_range(1, 100) > send_idle_pct) begin
        nxt = byte_feed.pop_front();
        in_ch.valid     <= 1'b1;
        in_ch.data_byte <= nxt.data;
        in_ch.last_byte <= nxt.last;
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // Receiver: random stalls, plus one long hold-off counted here.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else if (pressure_on && !pressure_done) begin
      if (hold_cnt == PRESSURE_HOLD) begin
        pressure_done <= 1'b1;
        out_ch.ready  <= 1'b1;
      end else begin
        hold_cnt     <= hold_cnt + 1;
        out_ch.ready <= 1'b0;
      end
    end else begin
      out_ch.ready <= ($urandom_range(1, 100) > recv_stall_pct);
    end
  end

  // Input monitor: every accepted byte goes through the model.
  always @(posedge clk) begin
    if (rst_n && in_ch.valid && in_ch.ready) begin
      sniff_byte(in_ch.data_byte, in_ch.last_byte);
      if (in_ch.last_byte) n_images++;
    end
    if (rst_n && in_ch.valid && !in_ch.ready) n_in_stalls++;
  end

  // Output monitor: each report against the oldest one due.
  always @(posedge clk) begin : report_check
    size_report_t due;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (size_reports_due.size() == 0) begin
        $error("unexpected report: found=%0d width=%h height=%h",
               out_ch.found, out_ch.image_width, out_ch.image_height);
        fails++;
      end else begin
        due = size_reports_due.pop_front();
        if (due.found) n_found++;
        else n_missing++;
        if (out_ch.found !== due.found) begin
          $error("found: expected %0d, got %0d", due.found, out_ch.found);
          fails++;
        end
        if (out_ch.image_width !== due.width) begin
          $error("image_width: expected %h, got %h", due.width, out_ch.image_width);
          fails++;
        end
        if (out_ch.image_height !== due.height) begin
          $error("image_height: expected %h, got %h", due.height, out_ch.image_height);
          fails++;
        end
      end
    end
  end

  // Watchdog: too long without a transfer on either side.
  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == QUIET_LIMIT) begin
      $display("timeout: no transfer for %0d cycles, %0d reports outstanding",
               QUIET_LIMIT, size_reports_due.size());
      $display("SCOREBOARD MISMATCH");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic wait_drained();
    while (byte_feed.size() != 0 || in_ch.valid || size_reports_due.size() != 0)
      @(negedge clk);
  endtask

  // --------------------------------------------------------------------------
  // Sequence
  // --------------------------------------------------------------------------
  initial begin
    rst_n           = 1'b0;
    in_ch.valid     = 1'b0;
    in_ch.data_byte = '0;
    in_ch.last_byte = 1'b0;
    out_ch.ready    = 1'b0;
    clear_sniffer();
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: unknown lead byte, lone PNG lead byte (truncated), GIF whose
    // size lands on the final byte, JPEG stopped by SOS, JPEG with length 1.
    put(8'h00); ship_img();
    put(SIG_PNG0); ship_img();
    put(SIG_G); put(SIG_I); put(SIG_F); put(8'h38); put(8'h39); put(8'h61);
    put(8'hff); put(8'hff); put(8'h00); put(8'h00); ship_img();
    put(MK_PREFIX); put(MK_SOI); put(MK_PREFIX); put(MK_SOS); put(8'h00); ship_img();
    put(MK_PREFIX); put(MK_SOI); put(MK_PREFIX); put(sof_marker());
    put(8'h00); put(8'h01); ship_img();
    wait_drained();

    // Random images under four idling mixes.
    for (int p = 0; p < 4; p++) begin
      @(negedge clk);
      case (p)
        0:       begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1:       begin send_idle_pct = 72; recv_stall_pct = 0;  end
        2:       begin send_idle_pct = 0;  recv_stall_pct = 72; end
        default: begin send_idle_pct = 32; recv_stall_pct = 32; end
      endcase
      gen_images(PHASE_BYTES);
      wait_drained();
    end

    // Back-pressure: short images give a report every few bytes while the
    // receiver holds off, so the core must stall its input.
    @(negedge clk);
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    while (byte_feed.size() < 150) gen_noise(3);
    pressure_on = 1'b1;
    while (!pressure_done) @(negedge clk);
    wait_drained();

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (size_reports_due.size() != 0) begin
      $error("%0d reports never arrived", size_reports_due.size());
      fails++;
    end

    $display("Run covered %0d images in %0d bytes: %0d sizes reported, %0d without size.",
             n_images, n_bytes, n_found, n_missing);
    $display("Input was held off for %0d cycles in total by output back-pressure.",
             n_in_stalls);
    if (fails == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
